// ===== src/assert_macros.svh =====
// Shared assertion macros for the checksum block.
// Every module that asserts has aclk and aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ACS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("acs: same-cycle check failed");

// Next-cycle implication
`define ACS_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("acs: next-cycle check failed");

`endif

// ===== src/acs_pkg.sv =====
package acs_pkg;

    // Sector geometry: 2352 bytes of 4-byte stereo samples
    localparam int unsigned SECTOR_BYTES   = 2352;
    localparam int unsigned SECTOR_SAMPLES = SECTOR_BYTES / 4;
    localparam int unsigned SKIP_SAMPLES   = 5 * SECTOR_SAMPLES;

    // Field widths
    localparam int unsigned SAMPLE_BITS    = 32;
    localparam int unsigned SUM_BITS       = 32;
    localparam int unsigned TRACK_BITS     = 28;
    localparam int unsigned CMP_BITS       = 33;

    // Defaults for top-level parameters
    localparam int unsigned POSITION_BITS_DEF = 28;
    localparam int unsigned FIFO_DEPTH_DEF    = 4;

    // Configuration port
    localparam int unsigned CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRACK_SAMPLES = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_TRACK   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LAST_TRACK    = 2'd2;

    // Classification of one item, front to back
    typedef struct packed {
        logic counted;
        logic last;
    } acs_flags_t;

    localparam int unsigned FLAGS_BITS = $bits(acs_flags_t);

endpackage

// ===== src/cd_audio_track_weighted_checksum_unit.sv =====
// Track checksum unit (AccurateRip V1/V2 style). Takes one stereo sample
// (two 16-bit channels in 32 bits) per item, numbers the samples of a track
// from one, and sums position*sample: V1 keeps the low 32 bits of each
// product, V2 adds both 32-bit halves, both modulo 2^32. With first_track
// set, positions 1..2940 add nothing; with last_track set, the final 2940
// positions add nothing; skipped samples still count towards the position.
// When the position reaches track_samples one item carries both sums out
// (m_tdata: checksum_v1 low, checksum_v2 high) and the unit restarts for
// the next track. Throughput is one sample per clock unless stalled, set
// by the single sample-by-position multiplier and accumulate stages; a
// four-entry queue between the input classifier and the multiply-accumulate
// pipe lets input and output stall independently. m_tvalid rises once a
// track's final sample has passed the queue, product and output registers.
// No clearing pass follows reset. The user must write registers via cfg_*
// only while the unit is idle (not enforced); cfg_ready is always high.
module cd_audio_track_weighted_checksum_unit #(
    parameter int unsigned POSITION_BITS = acs_pkg::POSITION_BITS_DEF,
    parameter int unsigned FIFO_DEPTH    = acs_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [acs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [acs_pkg::TRACK_BITS-1:0]        cfg_data,
    // samples in
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [acs_pkg::SAMPLE_BITS-1:0]       s_tdata,   // [31:0] sample
    // checksums out
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [2*acs_pkg::SUM_BITS-1:0]        m_tdata    // [31:0] v1, [63:32] v2
);

    import acs_pkg::*;

    localparam int unsigned ENTRY_BITS = FLAGS_BITS + POSITION_BITS + SAMPLE_BITS;

    logic                  push;
    logic                  pop;
    logic [ENTRY_BITS-1:0] push_data;
    logic [ENTRY_BITS-1:0] pop_data;
    logic                  fifo_full;
    logic                  fifo_empty;

    assign cfg_ready = 1'b1;

    acs_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_data (push_data),
        .fifo_full (fifo_full)
    );

    acs_fifo #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    acs_back #(
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop        (pop),
        .pop_data   (pop_data),
        .fifo_empty (fifo_empty),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

// ===== src/acs_fifo.sv =====
`include "assert_macros.svh"

module acs_fifo #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
    localparam logic [CNT_BITS-1:0] DEPTH_CNT = CNT_BITS'(DEPTH);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, payload only
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ACS_ASSERT_IMP(a_fifo_count_bound, 1'b1, count_reg <= DEPTH_CNT)

endmodule

// ===== src/acs_front.sv =====
`include "assert_macros.svh"

module acs_front #(
    parameter int unsigned POSITION_BITS = 28
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [acs_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [acs_pkg::TRACK_BITS-1:0]        cfg_data,
    // incoming samples
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [acs_pkg::SAMPLE_BITS-1:0]       s_tdata,
    // towards the queue
    output logic                                  push,
    output logic [acs_pkg::FLAGS_BITS+POSITION_BITS+acs_pkg::SAMPLE_BITS-1:0] push_data,
    input  logic                                  fifo_full
);

    import acs_pkg::*;

    logic [TRACK_BITS-1:0]    track_samples_reg;
    logic                     first_track_reg;
    logic                     last_track_reg;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    logic [POSITION_BITS-1:0] pos_inc;
    logic [CMP_BITS-1:0]      pos_ext;
    logic [CMP_BITS-1:0]      track_ext;
    logic                     skip_first;
    logic                     skip_last;
    acs_flags_t               flags;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_samples_reg <= TRACK_BITS'(1);
            first_track_reg   <= 1'b0;
            last_track_reg    <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TRACK_SAMPLES: track_samples_reg <= cfg_data;
                REG_FIRST_TRACK:   first_track_reg   <= cfg_data[0];
                REG_LAST_TRACK:    last_track_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_tready = !fifo_full;
    assign push     = s_tvalid && s_tready;

    // Classify the item by its 1-based position; compares run without wrap
    assign pos_inc    = pos_reg + 1'b1;
    assign pos_ext    = CMP_BITS'(pos_inc);
    assign track_ext  = CMP_BITS'(track_samples_reg);
    assign skip_first = first_track_reg && (pos_ext <= CMP_BITS'(SKIP_SAMPLES));
    assign skip_last  = last_track_reg && ((pos_ext + CMP_BITS'(SKIP_SAMPLES)) > track_ext);

    always_comb begin
        flags.counted = !skip_first && !skip_last;
        flags.last    = (pos_ext == track_ext);
    end

    assign push_data = {flags, pos_inc, s_tdata};

    // Position restarts after the final item of a track
    always_comb begin
        pos_next = pos_reg;
        if (push) begin
            pos_next = flags.last ? '0 : pos_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

    `ACS_ASSERT_NXT(a_front_pos_restart, push && flags.last, pos_reg == '0)

endmodule

// ===== src/acs_back.sv =====
`include "assert_macros.svh"

module acs_back #(
    parameter int unsigned POSITION_BITS = 28
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // from the queue
    output logic                                  pop,
    input  logic [acs_pkg::FLAGS_BITS+POSITION_BITS+acs_pkg::SAMPLE_BITS-1:0] pop_data,
    input  logic                                  fifo_empty,
    // results
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [2*acs_pkg::SUM_BITS-1:0]        m_tdata
);

    import acs_pkg::*;

    localparam int unsigned PROD_BITS = SAMPLE_BITS + POSITION_BITS;

    acs_flags_t               in_flags;
    logic [POSITION_BITS-1:0] in_pos;
    logic [SAMPLE_BITS-1:0]   in_sample;

    logic                     mul_valid_reg, mul_valid_next;
    acs_flags_t               mul_flags_reg;
    logic [PROD_BITS-1:0]     prod_reg;

    logic [SUM_BITS-1:0]      sum_v1_reg, sum_v2_reg;
    logic [SUM_BITS-1:0]      sum_v1_new, sum_v2_new;
    logic [SUM_BITS-1:0]      prod_lo, prod_hi;

    logic                     m_valid_reg, m_valid_next;
    logic [2*SUM_BITS-1:0]    m_data_reg;

    logic                     consume;
    logic                     load;

    assign {in_flags, in_pos, in_sample} = pop_data;

    // Multiply stage advances when the accumulate stage takes its item;
    // a final item waits only while an earlier result is still unread
    assign consume = mul_valid_reg && (!mul_flags_reg.last || !m_valid_reg || m_tready);
    assign load    = !mul_valid_reg || consume;
    assign pop     = load && !fifo_empty;

    assign mul_valid_next = load ? !fifo_empty : mul_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_valid_reg <= 1'b0;
        end else begin
            mul_valid_reg <= mul_valid_next;
        end
    end

    // Product register: position times sample
    always_ff @(posedge aclk) begin
        if (load) begin
            mul_flags_reg <= in_flags;
            prod_reg      <= PROD_BITS'(in_pos) * PROD_BITS'(in_sample);
        end
    end

    // Accumulate: V1 takes the low half, V2 both halves
    assign prod_lo = prod_reg[SUM_BITS-1:0];
    assign prod_hi = SUM_BITS'(prod_reg[PROD_BITS-1:SUM_BITS]);

    always_comb begin
        sum_v1_new = sum_v1_reg;
        sum_v2_new = sum_v2_reg;
        if (mul_flags_reg.counted) begin
            sum_v1_new = sum_v1_reg + prod_lo;
            sum_v2_new = sum_v2_reg + prod_hi + prod_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_v1_reg <= '0;
            sum_v2_reg <= '0;
        end else if (consume) begin
            if (mul_flags_reg.last) begin
                sum_v1_reg <= '0;
                sum_v2_reg <= '0;
            end else begin
                sum_v1_reg <= sum_v1_new;
                sum_v2_reg <= sum_v2_new;
            end
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (consume && mul_flags_reg.last) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && mul_flags_reg.last) begin
            m_data_reg <= {sum_v2_new, sum_v1_new};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `ACS_ASSERT_NXT(a_back_result_shown, consume && mul_flags_reg.last, m_valid_reg)
    `ACS_ASSERT_NXT(a_back_sums_cleared, consume && mul_flags_reg.last,
                    (sum_v1_reg == '0) && (sum_v2_reg == '0))

endmodule
